### hdl/rau_pkg.sv
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies; used by rational_arith_unit by scoped names
package rau_pkg;

  localparam int WIDTH = 32;
  localparam int DW    = 2 * WIDTH;
  localparam int CW    = $clog2(DW);

  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_SUB   = 3'd1,
    FN_MUL   = 3'd2,
    FN_DIV   = 3'd3,
    FN_SPLIT = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_COMB,
    S_GCD,
    S_DIV,
    S_POST,
    S_FIN
  } state_t;

endpackage

### hdl/rational_arith_unit.sv
// rational_arith_unit: signed fraction add/sub/mul/div with gcd reduction, and split
// depends on rau_pkg (types, widths, codes)
//
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_func, in_lhs_num, in_lhs_den, in_rhs_num, in_rhs_den
// out     | output    | out_valid, out_ready, out_res_num, out_res_den, out_int_part, out_status
//
// one transaction at a time; in_ready is high only in the idle state
// add/sub: multiplier states S_MUL1..S_MUL3, S_COMB, binary gcd (one shift or subtract per cycle),
//   then two 64-step divisions with a post state each
// mul/div: no S_MUL3; split: one 64-step division and its post state
// zero results, zero denominators and unused codes skip the divider; a waiting result holds finish
// reset (rst_n, synchronous) clears the sequencer and out_valid only
module rational_arith_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic signed [31:0] in_lhs_num,
  input  logic [30:0] in_lhs_den,
  input  logic signed [31:0] in_rhs_num,
  input  logic [30:0] in_rhs_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0] out_res_den,
  output logic signed [31:0] out_int_part,
  output logic [1:0]  out_status
);

  localparam logic [rau_pkg::DW-1:0] HALF = {{(rau_pkg::DW-1){1'b0}}, 1'b1} << (rau_pkg::WIDTH-1);
  localparam logic [rau_pkg::CW-1:0] CNT_LAST = {rau_pkg::CW{1'b1}};

  rau_pkg::state_t state_r, state_nxt;
  logic [2:0]  func_r, func_nxt;
  logic [31:0] am_r, am_nxt, cm_r, cm_nxt;
  logic        asg_r, asg_nxt, csg_r, csg_nxt;
  logic [30:0] b_r, b_nxt, d_r, d_nxt;
  logic [63:0] t1_r, t1_nxt, t2_r, t2_nxt;
  logic [63:0] nm_r, nm_nxt, dm_r, dm_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] ga_r, ga_nxt, gb_r, gb_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [63:0] dvs_r, dvs_nxt, dq_r, dq_nxt, dr_r, dr_nxt;
  logic [rau_pkg::CW-1:0] cnt_r, cnt_nxt;
  logic        phase_r, phase_nxt;
  logic [31:0] rn_r, rn_nxt, ri_r, ri_nxt;
  logic [30:0] rd_r, rd_nxt;
  logic [1:0]  rs_r, rs_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] on_r, on_nxt, oi_r, oi_nxt;
  logic [30:0] od_r, od_nxt;
  logic [1:0]  os_r, os_nxt;

  // shared multiplier
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;

  // combine terms, gcd and divider step
  logic signed [65:0] s1, s2, nsum;
  logic [63:0] nabs;
  logic [64:0] gdiff;
  logic [64:0] r2;
  logic [65:0] dsub;
  logic        dge;

  assign mul_p = mul_x * mul_y;

  always_comb begin
    s1    = asg_r ? -$signed({2'b00, t1_r}) : $signed({2'b00, t1_r});
    s2    = csg_r ? -$signed({2'b00, t2_r}) : $signed({2'b00, t2_r});
    nsum  = (func_r == rau_pkg::FN_ADD) ? s1 + s2 : s1 - s2;
    nabs  = nsum[65] ? 64'(-nsum) : nsum[63:0];
    gdiff = {1'b0, gb_r} - {1'b0, ga_r};
    r2    = {dr_r, dq_r[63]};
    dsub  = {1'b0, r2} - {2'b00, dvs_r};
    dge   = ~dsub[65];
  end

  // sequencer and datapath next values
  always_comb begin
    state_nxt = state_r;
    func_nxt = func_r; am_nxt = am_r; cm_nxt = cm_r; asg_nxt = asg_r; csg_nxt = csg_r;
    b_nxt = b_r; d_nxt = d_r; t1_nxt = t1_r; t2_nxt = t2_r;
    nm_nxt = nm_r; dm_nxt = dm_r; neg_nxt = neg_r;
    ga_nxt = ga_r; gb_nxt = gb_r; k_nxt = k_r;
    dvs_nxt = dvs_r; dq_nxt = dq_r; dr_nxt = dr_r; cnt_nxt = cnt_r; phase_nxt = phase_r;
    rn_nxt = rn_r; rd_nxt = rd_r; ri_nxt = ri_r; rs_nxt = rs_r;
    ov_nxt = ov_r; on_nxt = on_r; od_nxt = od_r; oi_nxt = oi_r; os_nxt = os_r;
    mul_x = am_r;
    mul_y = cm_r;
    in_ready = 1'b0;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      rau_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt = in_func;
          asg_nxt  = in_lhs_num[31];
          csg_nxt  = in_rhs_num[31];
          am_nxt   = in_lhs_num[31] ? 32'(-in_lhs_num) : in_lhs_num;
          cm_nxt   = in_rhs_num[31] ? 32'(-in_rhs_num) : in_rhs_num;
          b_nxt    = in_lhs_den;
          d_nxt    = in_rhs_den;
          rn_nxt   = '0;
          rd_nxt   = 31'd1;
          ri_nxt   = '0;
          rs_nxt   = rau_pkg::ST_OK;
          if (in_func > rau_pkg::FN_SPLIT) begin
            state_nxt = rau_pkg::S_FIN;
          end else if (in_lhs_den == '0 ||
                       (in_func != rau_pkg::FN_SPLIT && in_rhs_den == '0) ||
                       (in_func == rau_pkg::FN_DIV && in_rhs_num == '0)) begin
            rs_nxt    = rau_pkg::ST_ZDEN;
            state_nxt = rau_pkg::S_FIN;
          end else if (in_func == rau_pkg::FN_SPLIT) begin
            dq_nxt    = {32'd0, (in_lhs_num[31] ? 32'(-in_lhs_num) : in_lhs_num)};
            dvs_nxt   = {33'd0, in_lhs_den};
            dr_nxt    = '0;
            cnt_nxt   = '0;
            state_nxt = rau_pkg::S_DIV;
          end else begin
            state_nxt = rau_pkg::S_MUL1;
          end
        end
      end
      // first product: |a|*|c| for multiply, |a|*d otherwise
      rau_pkg::S_MUL1: begin
        mul_x     = am_r;
        mul_y     = (func_r == rau_pkg::FN_MUL) ? cm_r : {1'b0, d_r};
        t1_nxt    = mul_p;
        state_nxt = rau_pkg::S_MUL2;
      end
      // second product: b*d for multiply, |c|*b otherwise
      rau_pkg::S_MUL2: begin
        mul_x     = (func_r == rau_pkg::FN_MUL) ? {1'b0, b_r} : cm_r;
        mul_y     = (func_r == rau_pkg::FN_MUL) ? {1'b0, d_r} : {1'b0, b_r};
        t2_nxt    = mul_p;
        state_nxt = (func_r == rau_pkg::FN_ADD || func_r == rau_pkg::FN_SUB) ?
                    rau_pkg::S_MUL3 : rau_pkg::S_COMB;
      end
      // denominator product for add/sub
      rau_pkg::S_MUL3: begin
        mul_x     = {1'b0, b_r};
        mul_y     = {1'b0, d_r};
        dm_nxt    = mul_p;
        state_nxt = rau_pkg::S_COMB;
      end
      // form signed numerator magnitude, start gcd
      rau_pkg::S_COMB: begin
        if (func_r == rau_pkg::FN_ADD || func_r == rau_pkg::FN_SUB) begin
          nm_nxt  = nabs;
          neg_nxt = nsum[65];
          ga_nxt  = nabs;
        end else begin
          nm_nxt  = t1_r;
          dm_nxt  = t2_r;
          neg_nxt = asg_r ^ csg_r;
          ga_nxt  = t1_r;
        end
        gb_nxt = (func_r == rau_pkg::FN_ADD || func_r == rau_pkg::FN_SUB) ? dm_r : t2_r;
        k_nxt  = '0;
        if ((func_r == rau_pkg::FN_ADD || func_r == rau_pkg::FN_SUB) ? (nabs == '0)
                                                                     : (t1_r == '0)) begin
          state_nxt = rau_pkg::S_FIN;
        end else begin
          state_nxt = rau_pkg::S_GCD;
        end
      end
      // binary gcd, one shift or subtract per cycle
      rau_pkg::S_GCD: begin
        if (gb_r == '0) begin
          dvs_nxt   = ga_r << k_r;
          dq_nxt    = nm_r;
          dr_nxt    = '0;
          cnt_nxt   = '0;
          phase_nxt = 1'b0;
          state_nxt = rau_pkg::S_DIV;
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_nxt = ga_r >> 1;
          gb_nxt = gb_r >> 1;
          k_nxt  = k_r + 6'd1;
        end else if (!ga_r[0]) begin
          ga_nxt = ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_nxt = gb_r >> 1;
        end else if (gdiff[64]) begin
          ga_nxt = gb_r;
          gb_nxt = 64'(-gdiff);
        end else begin
          gb_nxt = gdiff[63:0];
        end
      end
      // restoring division, one quotient bit per cycle
      rau_pkg::S_DIV: begin
        dr_nxt  = dge ? dsub[63:0] : r2[63:0];
        dq_nxt  = {dq_r[62:0], dge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = rau_pkg::S_POST;
        end
      end
      rau_pkg::S_POST: begin
        state_nxt = rau_pkg::S_FIN;
        if (func_r == rau_pkg::FN_SPLIT) begin
          if (asg_r ? (dq_r > HALF) : (dq_r >= HALF)) begin
            rs_nxt = rau_pkg::ST_OVF;
          end else begin
            rn_nxt = asg_r ? 32'(-dr_r[31:0]) : dr_r[31:0];
            ri_nxt = asg_r ? 32'(-dq_r[31:0]) : dq_r[31:0];
            rd_nxt = b_r;
          end
        end else if (!phase_r) begin
          nm_nxt    = dq_r;
          dq_nxt    = dm_r;
          dr_nxt    = '0;
          cnt_nxt   = '0;
          phase_nxt = 1'b1;
          state_nxt = rau_pkg::S_DIV;
        end else if ((neg_r ? (nm_r > HALF) : (nm_r >= HALF)) || dq_r >= HALF) begin
          rs_nxt = rau_pkg::ST_OVF;
        end else begin
          rn_nxt = neg_r ? 32'(-nm_r[31:0]) : nm_r[31:0];
          rd_nxt = dq_r[30:0];
        end
      end
      // hand the result to the output register
      rau_pkg::S_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          on_nxt    = rn_r;
          od_nxt    = rd_r;
          oi_nxt    = ri_r;
          os_nxt    = rs_r;
          state_nxt = rau_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rau_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r <= func_nxt; am_r <= am_nxt; cm_r <= cm_nxt; asg_r <= asg_nxt; csg_r <= csg_nxt;
    b_r <= b_nxt; d_r <= d_nxt; t1_r <= t1_nxt; t2_r <= t2_nxt;
    nm_r <= nm_nxt; dm_r <= dm_nxt; neg_r <= neg_nxt;
    ga_r <= ga_nxt; gb_r <= gb_nxt; k_r <= k_nxt;
    dvs_r <= dvs_nxt; dq_r <= dq_nxt; dr_r <= dr_nxt; cnt_r <= cnt_nxt; phase_r <= phase_nxt;
    rn_r <= rn_nxt; rd_r <= rd_nxt; ri_r <= ri_nxt; rs_r <= rs_nxt;
    on_r <= on_nxt; od_r <= od_nxt; oi_r <= oi_nxt; os_r <= os_nxt;
  end

  assign out_valid    = ov_r;
  assign out_res_num  = on_r;
  assign out_res_den  = od_r;
  assign out_int_part = oi_r;
  assign out_status   = os_r;

  // error results are always 0/1 with no integer part
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != rau_pkg::ST_OK) |->
      (out_res_num == '0 && out_res_den == 31'd1 && out_int_part == '0))
    else $error("error result not cleared");

  // a delivered denominator is never zero
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res_den != '0)
    else $error("zero denominator delivered");

  // no new transaction while one is in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted back to back");

  // gcd operand a stays nonzero during reduction
  a_gcd_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rau_pkg::S_GCD) |-> ga_r != '0)
    else $error("gcd operand reached zero");

endmodule

### dv/rational_arith_unit_tb.sv
// rational_arith_unit_tb: self-checking bench for the rational arithmetic unit
// depends on rau_pkg and rational_arith_unit; predicts each result and compares per field
module rational_arith_unit_tb;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] lhs_num;
    logic [30:0] lhs_den;
    logic [31:0] rhs_num;
    logic [30:0] rhs_den;
  } frac_op_t;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [31:0] ipart;
    logic [1:0]  status;
  } frac_res_t;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_func;
  logic signed [31:0] in_lhs_num;
  logic [30:0] in_lhs_den;
  logic signed [31:0] in_rhs_num;
  logic [30:0] in_rhs_den;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic signed [31:0] out_int_part;
  logic [1:0] out_status;

  frac_op_t  op_queue[$];
  frac_res_t expected_q[$];
  int        fail_count = 0;
  bit        stim_done = 0;
  bit        hold_send = 0;
  bit        busy_idle = 1;
  int        quiet_cycles = 0;
  logic      in_ready_seen = 0;

  rational_arith_unit DUT (.*);

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // euclid gcd on magnitudes
  function automatic logic [63:0] gcd_mag(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    if (a == 0) return b;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic bit fits_width(bit neg, logic [63:0] m);
    return neg ? (m <= 64'h8000_0000) : (m <= 64'h7FFF_FFFF);
  endfunction

  function automatic frac_res_t reduce_fraction(frac_op_t op);
    frac_res_t r;
    logic signed [63:0] a, b, c, d, n;
    logic [63:0] nm, dm, g, q, rm;
    bit neg;
    r = '{num: 0, den: 1, ipart: 0, status: rau_pkg::ST_OK};
    a = $signed(op.lhs_num);
    b = {33'd0, op.lhs_den};
    c = $signed(op.rhs_num);
    d = {33'd0, op.rhs_den};
    if (op.func > rau_pkg::FN_SPLIT) return r;
    if (b == 0 || (op.func != rau_pkg::FN_SPLIT && d == 0) ||
        (op.func == rau_pkg::FN_DIV && c == 0)) begin
      r.status = rau_pkg::ST_ZDEN;
      return r;
    end
    if (op.func == rau_pkg::FN_SPLIT) begin
      neg = a < 0;
      nm = neg ? -a : a;
      q = nm / b;
      rm = nm % b;
      if (!fits_width(neg, q) || !fits_width(neg, rm)) begin
        r.status = rau_pkg::ST_OVF;
        return r;
      end
      r.num = 32'(neg ? -rm : rm);
      r.den = op.lhs_den;
      r.ipart = 32'(neg ? -q : q);
      return r;
    end
    if (op.func == rau_pkg::FN_DIV) begin
      neg = (a < 0) != (c < 0);
      nm = (a < 0 ? -a : a) * d;
      dm = b * (c < 0 ? -c : c);
    end else begin
      case (op.func)
        rau_pkg::FN_ADD: n = a * d + c * b;
        rau_pkg::FN_SUB: n = a * d - c * b;
        default:         n = a * c;
      endcase
      dm = b * d;
      neg = n < 0;
      nm = neg ? -n : n;
    end
    g = gcd_mag(nm, dm);
    nm = nm / g;
    dm = dm / g;
    if (nm == 0) neg = 0;
    if (!fits_width(neg, nm) || !fits_width(0, dm)) begin
      r.status = rau_pkg::ST_OVF;
      return r;
    end
    r.num = 32'(neg ? -nm : nm);
    r.den = dm[30:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_num(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 40) - 20;
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  function automatic frac_op_t rand_op();
    frac_op_t op;
    int mode;
    mode = $urandom_range(0, 2);
    op.func = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    op.lhs_num = rand_num(mode);
    op.rhs_num = rand_num(mode);
    op.lhs_den = (mode == 0) ? 31'($urandom) : 31'($urandom_range(1, 60));
    op.rhs_den = (mode == 0) ? 31'($urandom) : 31'($urandom_range(1, 60));
    if ($urandom_range(0, 60) == 0) op.lhs_den = 0;
    if ($urandom_range(0, 60) == 0) op.rhs_den = 0;
    return op;
  endfunction

  // stimulus
  initial begin
    rau_pkg::func_t f;
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    // directed: each operation at the field extremes plus the special cases
    for (int k = 0; k <= 4; k++) begin
      f = rau_pkg::func_t'(k);
      op_queue.push_back('{f, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'd1});
      op_queue.push_back('{f, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF});
      op_queue.push_back('{f, 32'd6, 31'd4, 32'hFFFF_FFFD, 31'd9});
    end
    op_queue.push_back('{rau_pkg::FN_ADD, 32'd1, 31'd2, 32'hFFFF_FFFF, 31'd2});
    op_queue.push_back('{rau_pkg::FN_MUL, 32'd0, 31'd5, 32'd7, 31'd3});
    op_queue.push_back('{rau_pkg::FN_ADD, 32'd1, 31'd0, 32'd1, 31'd1});
    op_queue.push_back('{rau_pkg::FN_SUB, 32'd1, 31'd1, 32'd1, 31'd0});
    op_queue.push_back('{rau_pkg::FN_SPLIT, 32'd7, 31'd0, 32'd1, 31'd0});
    op_queue.push_back('{rau_pkg::FN_SPLIT, 32'hFFFF_FFF9, 31'd2, 32'd0, 31'd0});
    op_queue.push_back('{rau_pkg::FN_DIV, 32'd3, 31'd4, 32'd0, 31'd5});
    op_queue.push_back('{3'd5, 32'd3, 31'd4, 32'd1, 31'd5});
    op_queue.push_back('{3'd7, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF});
    op_queue.push_back('{rau_pkg::FN_MUL, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1});
    wait (op_queue.size() == 0 && expected_q.size() == 0);
    // hold off the sender until the unit has drained
    hold_send = 1;
    repeat (50) @(posedge clk);
    wait (expected_q.size() == 0);
    hold_send = 0;
    for (int i = 0; i < 1425; i++) begin
      op_queue.push_back(rand_op());
      if (i == 500) begin
        busy_idle = 0;
        wait (op_queue.size() == 0);
      end
      if (i == 800) busy_idle = 1;
    end
    stim_done = 1;
  end

  // driver
  always @(negedge clk) begin
    frac_op_t op;
    if (!rst_n) begin
      in_valid <= 0;
      in_func <= 0;
      in_lhs_num <= 0;
      in_lhs_den <= 0;
      in_rhs_num <= 0;
      in_rhs_den <= 0;
    end else if ((!in_valid || in_ready_seen) && !hold_send && op_queue.size() > 0 &&
                 (!busy_idle || $urandom_range(0, 99) >= 37)) begin
      op = op_queue.pop_front();
      in_valid <= 1;
      in_func <= op.func;
      in_lhs_num <= op.lhs_num;
      in_lhs_den <= op.lhs_den;
      in_rhs_num <= op.rhs_num;
      in_rhs_den <= op.rhs_den;
    end else if (in_ready_seen) begin
      in_valid <= 0;
    end
  end

  // acceptance seen at the last rising edge
  always @(posedge clk) in_ready_seen <= rst_n && in_valid && in_ready;

  // receiver stalls
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 0;
    else out_ready <= !busy_idle || $urandom_range(0, 99) >= 37;
  end

  // monitor: predict on input transaction, compare on output transaction
  always @(posedge clk) begin
    frac_res_t exp_r;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_valid && in_ready) begin
        expected_q.push_back(reduce_fraction('{in_func, in_lhs_num, in_lhs_den,
                                               in_rhs_num, in_rhs_den}));
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_res_num !== exp_r.num) begin
            $error("res_num expected %0d got %0d", $signed(exp_r.num), out_res_num);
            fail_count++;
          end
          if (out_res_den !== exp_r.den) begin
            $error("res_den expected %0d got %0d", exp_r.den, out_res_den);
            fail_count++;
          end
          if (out_int_part !== exp_r.ipart) begin
            $error("int_part expected %0d got %0d", $signed(exp_r.ipart), out_int_part);
            fail_count++;
          end
          if (out_status !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, out_status);
            fail_count++;
          end
        end
      end
    end
  end

  // end of run and watchdog
  initial begin
    fork
      begin
        wait (stim_done && op_queue.size() == 0 && !in_valid && expected_q.size() == 0);
        repeat (400) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0) $display("rational_arith_unit_tb: PASS");
        else $display("rational_arith_unit_tb: FAIL");
      end
      begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("rational_arith_unit_tb: FAIL");
      end
    join_any
    $finish;
  end

endmodule

### sim.f
hdl/rau_pkg.sv
hdl/rational_arith_unit.sv
dv/rational_arith_unit_tb.sv
